// File: hw/rtl/pksw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksw_pkg
// Types and constants shared by the per-key sliding window limiter.
// ----------------------------------------------------------------------------
package pksw_pkg;

  localparam int KEY_SLOTS = 16;
  localparam int MAX_LIMIT = 64;
  localparam int TIME_BITS = 32;

  localparam int KEY_BITS   = $clog2(KEY_SLOTS);
  localparam int POS_BITS   = $clog2(MAX_LIMIT);
  localparam int CNT_BITS   = $clog2(MAX_LIMIT + 1);
  localparam int ADDR_BITS  = KEY_BITS + POS_BITS;
  localparam int DEPTH      = KEY_SLOTS * MAX_LIMIT;

  localparam int LIMIT_BITS  = 7;
  localparam int WINDOW_BITS = 16;
  localparam int MERGE_BITS  = 8;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [LIMIT_BITS-1:0]  LIMIT_RST  = 7'd10;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RST = 16'd1000;
  localparam logic [MERGE_BITS-1:0]  MERGE_RST  = 8'd10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RATE_LIMIT = 2'd0,
    CFG_WINDOW_MS  = 2'd1,
    CFG_MERGE_MS   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  key_slot;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       allowed;
    logic [6:0] count_in_window;
  } out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic [CNT_BITS-1:0]  count;
  } bucket_t;

endpackage

// File: hw/rtl/per_key_sliding_window_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_sliding_window_limiter
// Sliding-window rate limiter with a ring of time buckets per key slot.
// ----------------------------------------------------------------------------
// Usage:
//   A request (key slot, tick time) is taken on a clock edge with start high
//   and busy low. busy stays high while the request is worked on. One result
//   (allowed, count in window) shows on out_data for exactly one cycle with
//   out_valid high; busy is already low in that cycle, so the next request
//   can be started at once. The receiver cannot stall the block.
//   After the accept, expired buckets are dropped from the ring head one by
//   one (up to 64); the verdict then follows directly when the key has no
//   live bucket or is at its limit, else after the newest bucket is fetched.
//   The steps follow the bucket memory: one read per cycle with registered
//   read data, used first to walk expired buckets from the ring head and
//   then to fetch the newest bucket for the merge test.
//   Configuration (request limit, window length, merge age) is written
//   through cfg_we, cfg_index and cfg_data; the user must do so only while
//   the block is idle, as the block itself does not enforce it.
//   Reset restores the default configuration and empties every ring at once;
//   the bucket memory itself is not cleared, only data of live buckets is used.
// ----------------------------------------------------------------------------
module per_key_sliding_window_limiter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  pksw_pkg::in_t                           in_data,
  output logic                                    out_valid,
  output pksw_pkg::out_t                          out_data,
  input  logic                                    cfg_we,
  input  logic [pksw_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [pksw_pkg::CFG_BITS-1:0]           cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DECIDE,
    S_TAIL
  } state_t;

  localparam logic [pksw_pkg::CNT_BITS-1:0] MAX_CNT =
    pksw_pkg::CNT_BITS'(pksw_pkg::MAX_LIMIT);
  localparam logic [pksw_pkg::CNT_BITS-1:0] ONE_CNT = pksw_pkg::CNT_BITS'(1);

  // configuration
  logic [pksw_pkg::LIMIT_BITS-1:0]  limit_r;
  logic [pksw_pkg::WINDOW_BITS-1:0] window_r;
  logic [pksw_pkg::MERGE_BITS-1:0]  merge_r;

  // per-key ring control
  logic [pksw_pkg::POS_BITS-1:0] ring_head_r [pksw_pkg::KEY_SLOTS];
  logic [pksw_pkg::CNT_BITS-1:0] ring_used_r [pksw_pkg::KEY_SLOTS];
  logic [pksw_pkg::CNT_BITS-1:0] win_total_r [pksw_pkg::KEY_SLOTS];

  // bucket memory
  pksw_pkg::bucket_t                mem [pksw_pkg::DEPTH];
  pksw_pkg::bucket_t                rdata_r;
  logic                             mem_re;
  logic [pksw_pkg::ADDR_BITS-1:0]   mem_raddr;
  logic                             mem_we;
  logic [pksw_pkg::ADDR_BITS-1:0]   mem_waddr;
  pksw_pkg::bucket_t                mem_wdata;

  // working registers
  state_t                           state_r, state_nxt;
  logic [pksw_pkg::KEY_BITS-1:0]    key_r, key_nxt;
  logic [pksw_pkg::TIME_BITS-1:0]   now_r, now_nxt;
  logic [pksw_pkg::POS_BITS-1:0]    head_r, head_nxt;
  logic [pksw_pkg::CNT_BITS-1:0]    used_r, used_nxt;
  logic [pksw_pkg::CNT_BITS-1:0]    total_r, total_nxt;
  logic                             commit;
  logic                             out_valid_r, out_valid_nxt;
  pksw_pkg::out_t                   out_data_r, out_data_nxt;

  logic [pksw_pkg::KEY_BITS-1:0]    in_key;
  logic [pksw_pkg::CNT_BITS-1:0]    limit_eff;
  logic [pksw_pkg::TIME_BITS-1:0]   age;
  logic                             expired;
  logic                             join_tail;
  logic [pksw_pkg::POS_BITS-1:0]    head_inc;
  logic [pksw_pkg::POS_BITS-1:0]    tail_pos;
  logic [pksw_pkg::POS_BITS-1:0]    new_pos;
  logic [pksw_pkg::CNT_BITS-1:0]    used_dec;

  assign in_key    = in_data.key_slot[pksw_pkg::KEY_BITS-1:0];
  assign limit_eff = (pksw_pkg::CNT_BITS'(limit_r) > MAX_CNT) ? MAX_CNT
                                                              : pksw_pkg::CNT_BITS'(limit_r);
  assign age       = now_r - rdata_r.stamp;
  assign expired   = age > pksw_pkg::TIME_BITS'(window_r);
  assign join_tail = (age < pksw_pkg::TIME_BITS'(merge_r)) || (used_r == MAX_CNT);
  assign head_inc  = head_r + pksw_pkg::POS_BITS'(1);
  assign tail_pos  = head_r + used_r[pksw_pkg::POS_BITS-1:0] - pksw_pkg::POS_BITS'(1);
  assign new_pos   = head_r + used_r[pksw_pkg::POS_BITS-1:0];
  assign used_dec  = used_r - ONE_CNT;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    commit        = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_raddr     = {key_r, head_r};
    mem_we        = 1'b0;
    mem_waddr     = {key_r, new_pos};
    mem_wdata     = '{stamp: now_r, count: ONE_CNT};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = in_key;
          now_nxt   = in_data.now_ms;
          head_nxt  = ring_head_r[in_key];
          used_nxt  = ring_used_r[in_key];
          total_nxt = win_total_r[in_key];
          // fetch the oldest bucket right away
          mem_re    = 1'b1;
          mem_raddr = {in_key, ring_head_r[in_key]};
          state_nxt = (ring_used_r[in_key] != '0) ? S_POP : S_DECIDE;
        end
      end

      S_POP: begin
        if (expired) begin
          total_nxt = (total_r >= rdata_r.count) ? total_r - rdata_r.count : '0;
          head_nxt  = head_inc;
          used_nxt  = used_dec;
          mem_re    = 1'b1;
          mem_raddr = {key_r, head_inc};
          state_nxt = (used_dec != '0) ? S_POP : S_DECIDE;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (total_r >= limit_eff) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{allowed: 1'b0, count_in_window: 7'(total_r)};
          state_nxt     = S_IDLE;
        end else if (used_r == '0) begin
          mem_we        = 1'b1;
          mem_waddr     = {key_r, head_r};
          used_nxt      = ONE_CNT;
          total_nxt     = total_r + ONE_CNT;
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{allowed: 1'b1, count_in_window: 7'(total_r + ONE_CNT)};
          state_nxt     = S_IDLE;
        end else begin
          // fetch the newest bucket for the merge test
          mem_re    = 1'b1;
          mem_raddr = {key_r, tail_pos};
          state_nxt = S_TAIL;
        end
      end

      S_TAIL: begin
        mem_we = 1'b1;
        if (join_tail) begin
          mem_waddr = {key_r, tail_pos};
          mem_wdata = '{stamp: rdata_r.stamp, count: rdata_r.count + ONE_CNT};
        end else begin
          mem_waddr = {key_r, new_pos};
          used_nxt  = used_r + ONE_CNT;
        end
        total_nxt     = total_r + ONE_CNT;
        commit        = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{allowed: 1'b1, count_in_window: 7'(total_r + ONE_CNT)};
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // bucket memory: one read, one write port, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= pksw_pkg::LIMIT_RST;
      window_r    <= pksw_pkg::WINDOW_RST;
      merge_r     <= pksw_pkg::MERGE_RST;
      for (int i = 0; i < pksw_pkg::KEY_SLOTS; i++) begin
        ring_head_r[i] <= '0;
        ring_used_r[i] <= '0;
        win_total_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pksw_pkg::CFG_RATE_LIMIT: limit_r  <= cfg_data[pksw_pkg::LIMIT_BITS-1:0];
          pksw_pkg::CFG_WINDOW_MS:  window_r <= cfg_data[pksw_pkg::WINDOW_BITS-1:0];
          pksw_pkg::CFG_MERGE_MS:   merge_r  <= cfg_data[pksw_pkg::MERGE_BITS-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        ring_head_r[key_r] <= head_nxt;
        ring_used_r[key_r] <= used_nxt;
        win_total_r[key_r] <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    head_r     <= head_nxt;
    used_r     <= used_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result strobe only comes once the block is ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not raise busy");

  a_allowed_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.allowed) |-> (out_data.count_in_window != '0))
    else $error("admitted request with empty window");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pksw_pkg::CNT_BITS'(out_data.count_in_window) <= MAX_CNT))
    else $error("window count above capacity");

endmodule

// File: tb/pksw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksw_checker
// Watches the request, result and register ports of the limiter. It keeps its
// own copy of every key's bucket ring and predicts each verdict. Results are
// compared in order, and the running count of bad results goes to the top.
// ----------------------------------------------------------------------------
module pksw_checker
  import pksw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  in_t                     in_data,
  input  logic                    out_valid,
  input  out_t                    out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      error_count,
  output int                      in_flight
);

  localparam int VQ_DEPTH = 4;

  logic [LIMIT_BITS-1:0]  limit_reg;
  logic [WINDOW_BITS-1:0] window_reg;
  logic [MERGE_BITS-1:0]  merge_reg;

  logic [TIME_BITS-1:0] stamp_mem [KEY_SLOTS][MAX_LIMIT];
  int unsigned          tally_mem [KEY_SLOTS][MAX_LIMIT];
  int unsigned          oldest    [KEY_SLOTS];
  int unsigned          live      [KEY_SLOTS];
  int unsigned          key_total [KEY_SLOTS];

  // expected verdicts, oldest first
  out_t        verdict_fifo [VQ_DEPTH];
  int unsigned vq_rd;
  int unsigned vq_wr;
  int unsigned vq_count;
  int          bad_results;

  function automatic out_t admit_request(in_t req);
    int unsigned          k;
    int unsigned          pos;
    int unsigned          cap;
    logic [TIME_BITS-1:0] age;
    logic                 expiring;
    logic                 merged;
    out_t                 res;
    k = req.key_slot;
    // pop buckets from the ring head while they are older than the window
    expiring = 1'b1;
    while (live[k] > 0 && expiring) begin
      pos = oldest[k];
      age = req.now_ms - stamp_mem[k][pos];
      if (age <= window_reg) begin
        expiring = 1'b0;
      end else begin
        key_total[k] = (key_total[k] >= tally_mem[k][pos]) ?
                       key_total[k] - tally_mem[k][pos] : 0;
        oldest[k] = (oldest[k] + 1) % MAX_LIMIT;
        live[k] = live[k] - 1;
      end
    end
    cap = (limit_reg > MAX_LIMIT) ? MAX_LIMIT : limit_reg;
    res.allowed = 1'b0;
    if (key_total[k] < cap) begin
      merged = 1'b0;
      if (live[k] > 0) begin
        pos = (oldest[k] + live[k] - 1) % MAX_LIMIT;
        age = req.now_ms - stamp_mem[k][pos];
        if (age < merge_reg) begin
          tally_mem[k][pos] = tally_mem[k][pos] + 1;
          merged = 1'b1;
        end
      end
      if (!merged) begin
        if (live[k] < MAX_LIMIT) begin
          pos = (oldest[k] + live[k]) % MAX_LIMIT;
          stamp_mem[k][pos] = req.now_ms;
          tally_mem[k][pos] = 1;
          live[k] = live[k] + 1;
        end else begin
          pos = (oldest[k] + live[k] - 1) % MAX_LIMIT;
          tally_mem[k][pos] = tally_mem[k][pos] + 1;
        end
      end
      key_total[k] = key_total[k] + 1;
      res.allowed = 1'b1;
    end
    res.count_in_window = 7'(key_total[k]);
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      limit_reg  = LIMIT_RST;
      window_reg = WINDOW_RST;
      merge_reg  = MERGE_RST;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        oldest[k]    = 0;
        live[k]      = 0;
        key_total[k] = 0;
      end
      vq_rd       = 0;
      vq_wr       = 0;
      vq_count    = 0;
      bad_results = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RATE_LIMIT: limit_reg  = cfg_data[LIMIT_BITS-1:0];
          CFG_WINDOW_MS:  window_reg = cfg_data[WINDOW_BITS-1:0];
          CFG_MERGE_MS:   merge_reg  = cfg_data[MERGE_BITS-1:0];
          default: ;
        endcase
      end
      // the result of an older request can leave on the edge a new one is taken
      if (out_valid) begin
        if (vq_count == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result with no request pending: allowed=%0b count=%0d",
                     $realtime, out_data.allowed, out_data.count_in_window);
        end else begin
          want     = verdict_fifo[vq_rd];
          vq_rd    = (vq_rd + 1) % VQ_DEPTH;
          vq_count = vq_count - 1;
          if (out_data.allowed !== want.allowed ||
              out_data.count_in_window !== want.count_in_window) begin
            bad_results++;
            if (bad_results <= 10)
              $display({"%0t: verdict mismatch: expected allowed=%0b count=%0d,",
                        " got allowed=%0b count=%0d"},
                       $realtime, want.allowed, want.count_in_window,
                       out_data.allowed, out_data.count_in_window);
          end
        end
      end
      if (start && !busy) begin
        want = admit_request(in_data);
        if (vq_count == VQ_DEPTH) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: request taken with too many results pending", $realtime);
        end else begin
          verdict_fifo[vq_wr] = want;
          vq_wr    = (vq_wr + 1) % VQ_DEPTH;
          vq_count = vq_count + 1;
        end
      end
    end
    error_count <= bad_results;
    in_flight   <= int'(vq_count);
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request stimulus for the per-key sliding window limiter. A directed opening
// hits merge and expiry edges, time wrap and the limit; random phases then
// run under several register settings, extremes included, with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import pksw_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  in_t                     in_data;
  logic                    out_valid;
  out_t                    out_data;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  int error_count;
  int in_flight;
  int cycle_count;

  logic [TIME_BITS-1:0] key_clock [KEY_SLOTS];
  int                   cur_window;
  int                   cur_merge;
  int                   calm_left;

  per_key_sliding_window_limiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pksw_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .in_flight   (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mostly back to back or short gaps, now and then a long one or a calm run
  function automatic int pick_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input logic [3:0] key, input logic [TIME_BITS-1:0] t);
    int  gap;
    in_t req;
    gap = pick_gap();
    req.key_slot = key;
    req.now_ms   = t;
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  // upper data bits beyond each register are random and must be ignored
  task automatic apply_settings(input int limit, input int window, input int merge);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RATE_LIMIT;
    cfg_data  <= {9'($urandom_range(0, 511)), 7'(limit)};
    @(posedge clk);
    cfg_index <= CFG_WINDOW_MS;
    cfg_data  <= 16'(window);
    @(posedge clk);
    cfg_index <= CFG_MERGE_MS;
    cfg_data  <= {8'($urandom_range(0, 255)), 8'(merge)};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_window = window;
    cur_merge  = merge;
  endtask

  // per-key time walks forward in merge-sized steps, sometimes jumps past the
  // window, steps back, or lands anywhere
  task automatic random_request(input int hot_keys);
    logic [3:0]           key;
    logic [TIME_BITS-1:0] t;
    int                   sel;
    if ($urandom_range(0, 9) < 7) key = 4'($urandom_range(0, hot_keys - 1));
    else key = 4'($urandom_range(0, KEY_SLOTS - 1));
    sel = $urandom_range(0, 39);
    if (sel == 0) t = $urandom();
    else if (sel == 1) t = key_clock[key] - $urandom_range(1, 40);
    else if (sel < 4) t = key_clock[key] + cur_window + $urandom_range(0, cur_merge + 2);
    else if (sel < 8) t = key_clock[key] + $urandom_range(0, cur_window / 4 + 1);
    else t = key_clock[key] + $urandom_range(0, cur_merge + 3);
    key_clock[key] = t;
    issue(key, t);
  endtask

  task automatic run_random(input int count, input int hot_keys);
    for (int n = 0; n < count; n++) begin
      random_request(hot_keys);
      if ($urandom_range(0, 79) == 0) drain();
    end
  endtask

  initial begin
    logic [TIME_BITS-1:0] base;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cur_window = WINDOW_RST;
    cur_merge  = MERGE_RST;
    calm_left  = 0;
    for (int k = 0; k < KEY_SLOTS; k++) key_clock[k] = $urandom();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default settings: merge just below and at the merge age, window edge
    issue(4'd0, 32'd0);
    issue(4'd0, 32'd9);
    issue(4'd0, 32'd10);
    issue(4'd0, 32'd1000);
    issue(4'd0, 32'd1001);
    // time wrap, then time going backwards
    issue(4'd15, 32'hFFFF_FFFF);
    issue(4'd15, 32'd3);
    issue(4'd15, 32'hFFFF_FFF0);
    issue(4'd7, 32'h8000_0000);
    issue(4'd8, 32'h7FFF_FFFF);
    // one key driven past its limit
    for (int n = 0; n < 11; n++) issue(4'd3, 32'd100);

    run_random(200, 4);

    // limit of one, zero window, no merging
    apply_settings(1, 0, 0);
    run_random(80, 4);

    // fill one key's ring with 64 buckets, then expire them all at once
    apply_settings(64, 65535, 0);
    base = key_clock[5];
    for (int n = 0; n < 70; n++) issue(4'd5, base + n);
    key_clock[5] = base + 69 + 65537;
    issue(4'd5, key_clock[5]);
    run_random(130, 6);

    // limit above ring capacity, widest merge age
    apply_settings(127, 300, 255);
    run_random(150, 4);

    // limit of zero refuses every request
    apply_settings(0, 500, 20);
    run_random(30, 16);

    for (int p = 0; p < 4; p++) begin
      apply_settings($urandom_range(0, 127),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 400),
                     $urandom_range(0, 255));
      run_random(70, 3);
    end

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && in_flight == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
